@@ sv/tpft_pkg.sv @@
package tpft_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int QWIDTH         = 16;
  localparam int PWIDTH         = 21;

  typedef logic signed [QWIDTH-1:0] qword_t;
  typedef logic signed [PWIDTH-1:0] pword_t;
  typedef qword_t quat_t [4];
  typedef pword_t vec_t [3];

  typedef logic signed [47:0] acc_t;
  typedef logic signed [25:0] tword_t;
  typedef logic signed [29:0] mword_t;
  typedef tword_t tvec_t [3];
  typedef mword_t mvec_t [3];

  // round(2^QUAT_FRAC_BITS * sqrt(1/2))
  localparam qword_t HALF_ROOT = 16'sd11585;
  localparam pword_t ONE_P     = PWIDTH'(1 << QUAT_FRAC_BITS);
  localparam vec_t   EX_VEC    = '{ONE_P, '0, '0};
  localparam vec_t   EZ_VEC    = '{'0, '0, ONE_P};
  localparam vec_t   ZERO_VEC  = '{'0, '0, '0};

  typedef enum logic [2:0] {
    CFG_OFS_ROT  = 3'd0,
    CFG_OFS_TRN  = 3'd1,
    CFG_REF_ROT  = 3'd2,
    CFG_REF_TRN  = 3'd3,
    CFG_REF_KIND = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TR_RUNNING      = 2'd0,
    TR_OUT_OF_RANGE = 2'd1,
    TR_CALIBRATING  = 2'd2,
    TR_UNINIT       = 2'd3
  } track_res_e;

  typedef struct packed {
    logic       conn;
    logic       run;
    track_res_e res;
  } status_t;

  function automatic acc_t smul(input qword_t a, input mword_t b);
    smul = acc_t'(a) * acc_t'(b);
  endfunction

  // round half up, then floor shift
  function automatic acc_t rnd(input acc_t x);
    rnd = (x + (acc_t'(1) <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
  endfunction

  function automatic qword_t sat_q(input acc_t x);
    if (x > acc_t'(32767)) begin
      sat_q = 16'sh7fff;
    end else if (x < acc_t'(-32768)) begin
      sat_q = 16'sh8000;
    end else begin
      sat_q = QWIDTH'(x);
    end
  endfunction

  function automatic pword_t sat_p(input acc_t x);
    if (x > acc_t'(1048575)) begin
      sat_p = 21'sh0fffff;
    end else if (x < acc_t'(-1048576)) begin
      sat_p = 21'sh100000;
    end else begin
      sat_p = PWIDTH'(x);
    end
  endfunction

  function automatic quat_t qmul(input quat_t a, input quat_t b);
    acc_t  t0, t1, t2, t3;
    quat_t r;
    t0 = smul(a[0], mword_t'(b[0])) - smul(a[1], mword_t'(b[1]))
       - smul(a[2], mword_t'(b[2])) - smul(a[3], mword_t'(b[3]));
    t1 = smul(a[0], mword_t'(b[1])) + smul(a[1], mword_t'(b[0]))
       + smul(a[2], mword_t'(b[3])) - smul(a[3], mword_t'(b[2]));
    t2 = smul(a[0], mword_t'(b[2])) - smul(a[1], mword_t'(b[3]))
       + smul(a[2], mword_t'(b[0])) + smul(a[3], mword_t'(b[1]));
    t3 = smul(a[0], mword_t'(b[3])) + smul(a[1], mword_t'(b[2]))
       - smul(a[2], mword_t'(b[1])) + smul(a[3], mword_t'(b[0]));
    r[0] = sat_q(rnd(t0));
    r[1] = sat_q(rnd(t1));
    r[2] = sat_q(rnd(t2));
    r[3] = sat_q(rnd(t3));
    return r;
  endfunction

  function automatic vec_t vsat_q(input vec_t v);
    vec_t r;
    for (int k = 0; k < 3; k++) begin
      r[k] = PWIDTH'(sat_q(acc_t'(v[k])));
    end
    return r;
  endfunction

  // quarter turn about axis a (axis already in quaternion range)
  function automatic quat_t qturn(input vec_t a, input logic neg);
    acc_t  p;
    quat_t r;
    r[0] = HALF_ROOT;
    for (int k = 0; k < 3; k++) begin
      p = smul(HALF_ROOT, mword_t'(a[k]));
      r[k+1] = sat_q(rnd(neg ? -p : p));
    end
    return r;
  endfunction

  function automatic quat_t unpack_q(input logic [63:0] v);
    quat_t r;
    r[0] = $signed(v[63:48]);
    r[1] = $signed(v[47:32]);
    r[2] = $signed(v[31:16]);
    r[3] = $signed(v[15:0]);
    return r;
  endfunction

  function automatic vec_t unpack_p(input logic [62:0] v);
    vec_t r;
    r[0] = $signed(v[62:42]);
    r[1] = $signed(v[41:21]);
    r[2] = $signed(v[20:0]);
    return r;
  endfunction

endpackage

@@ sv/tpft_rotate.sv @@
module tpft_rotate (
  input  logic           clk_i,
  input  logic [2:0]     en_i,
  input  tpft_pkg::quat_t q_i,
  input  tpft_pkg::vec_t  v_i,
  input  tpft_pkg::vec_t  ofs_i,
  output tpft_pkg::vec_t  r_o
);
  import tpft_pkg::*;

  quat_t q_a_q;
  vec_t  v_a_q, v_b_q;
  tvec_t t_d, t_q;
  mvec_t wt_d, wt_q, o_d, o_q;
  vec_t  r_d, r_q;

  // t = rnd(2 * (u x v))
  always_comb begin
    t_d[0] = tword_t'(rnd((smul(q_i[2], mword_t'(v_i[2]))
                         - smul(q_i[3], mword_t'(v_i[1]))) <<< 1));
    t_d[1] = tword_t'(rnd((smul(q_i[3], mword_t'(v_i[0]))
                         - smul(q_i[1], mword_t'(v_i[2]))) <<< 1));
    t_d[2] = tword_t'(rnd((smul(q_i[1], mword_t'(v_i[1]))
                         - smul(q_i[2], mword_t'(v_i[0]))) <<< 1));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wt_d[k] = mword_t'(rnd(smul(q_a_q[0], mword_t'(t_q[k]))));
    end
    o_d[0] = mword_t'(rnd(smul(q_a_q[2], mword_t'(t_q[2]))
                        - smul(q_a_q[3], mword_t'(t_q[1]))));
    o_d[1] = mword_t'(rnd(smul(q_a_q[3], mword_t'(t_q[0]))
                        - smul(q_a_q[1], mword_t'(t_q[2]))));
    o_d[2] = mword_t'(rnd(smul(q_a_q[1], mword_t'(t_q[1]))
                        - smul(q_a_q[2], mword_t'(t_q[0]))));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_d[k] = sat_p(acc_t'(sat_p(acc_t'(v_b_q[k]) + acc_t'(wt_q[k]) + acc_t'(o_q[k])))
                   + acc_t'(ofs_i[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q_a_q <= q_i;
      v_a_q <= v_i;
      t_q   <= t_d;
    end
    if (en_i[1]) begin
      v_b_q <= v_a_q;
      wt_q  <= wt_d;
      o_q   <= o_d;
    end
    if (en_i[2]) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

@@ sv/tpft_datapath.sv @@
module tpft_datapath (
  input  logic            clk_i,
  input  logic [8:0]      en_i,
  input  tpft_pkg::vec_t  pp_i,
  input  tpft_pkg::quat_t qp_i,
  input  tpft_pkg::quat_t qo_i,
  input  tpft_pkg::vec_t  to_i,
  input  tpft_pkg::quat_t qr_i,
  input  tpft_pkg::vec_t  tr_i,
  input  logic            kind_i,
  output tpft_pkg::vec_t  pos_o,
  output tpft_pkg::quat_t rot_o
);
  import tpft_pkg::*;

  quat_t q1_q;
  quat_t q2_q [7];
  quat_t qc_d;
  quat_t qc_q [3];
  quat_t qx_q [2];
  quat_t qz_q;
  quat_t m1_q, m2_q, rot_q;
  vec_t  p1, p2, rx, xa, za, rx16;

  tpft_rotate u_p1 (.clk_i, .en_i(en_i[2:0]), .q_i(qo_i), .v_i(pp_i), .ofs_i(to_i),
                    .r_o(p1));
  tpft_rotate u_rx (.clk_i, .en_i(en_i[2:0]), .q_i(qr_i), .v_i(EX_VEC), .ofs_i(ZERO_VEC),
                    .r_o(rx));
  tpft_rotate u_xa (.clk_i, .en_i(en_i[4:2]), .q_i(q2_q[0]), .v_i(EX_VEC),
                    .ofs_i(ZERO_VEC), .r_o(xa));
  tpft_rotate u_za (.clk_i, .en_i(en_i[4:2]), .q_i(q2_q[0]), .v_i(EZ_VEC),
                    .ofs_i(ZERO_VEC), .r_o(za));
  tpft_rotate u_p2 (.clk_i, .en_i(en_i[5:3]), .q_i(qr_i), .v_i(p1), .ofs_i(ZERO_VEC),
                    .r_o(p2));
  tpft_rotate u_p3 (.clk_i, .en_i(en_i[8:6]), .q_i(qc_q[2]), .v_i(p2), .ofs_i(tr_i),
                    .r_o(pos_o));

  assign rx16 = vsat_q(rx);

  always_comb begin
    if (kind_i) begin
      qc_d = qturn(rx16, 1'b0);
    end else begin
      qc_d = '{16'sd0, QWIDTH'(rx16[0]), QWIDTH'(rx16[1]), QWIDTH'(rx16[2])};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) q1_q <= qmul(qo_i, qp_i);
    if (en_i[1]) q2_q[0] <= qmul(qr_i, q1_q);
    for (int i = 1; i < 7; i++) begin
      if (en_i[1+i]) q2_q[i] <= q2_q[i-1];
    end
    if (en_i[3]) qc_q[0] <= qc_d;
    if (en_i[4]) qc_q[1] <= qc_q[0];
    if (en_i[5]) begin
      qc_q[2] <= qc_q[1];
      qx_q[0] <= qturn(vsat_q(xa), 1'b0);
      qz_q    <= qturn(vsat_q(za), 1'b1);
    end
    if (en_i[6]) begin
      qx_q[1] <= qx_q[0];
      m1_q    <= qmul(qc_q[2], qz_q);
    end
    if (en_i[7]) m2_q <= qmul(m1_q, qx_q[1]);
    if (en_i[8]) rot_q <= qmul(m2_q, q2_q[6]);
  end

  assign rot_o = rot_q;

endmodule

@@ sv/tracked_pose_frame_transform.sv @@
// Pen pose frame transform.
// Input channel: in_valid_i/in_ready_o carry one pen pose (Q6.14 position,
// Q1.14 quaternion) and four status flags per beat. Output channel:
// out_valid_o/out_ready_i carry one transformed pose and status per beat.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 offset rotation, 1 offset translation, 2 reference rotation,
// 3 reference translation, 4 reference kind); write only while idle.
// Throughput: one beat per cycle while the receiver accepts; the nine
// register stages are set by the chain of three rotations on the position
// and five quaternion products on the rotation.
// A pose whose status is not running comes out with a zero pose.
// Reset clears all stage valid bits and loads identity rotations, zero
// translations and half turn reference kind.
// When the receiver stalls, the pipeline keeps accepting beats into empty
// stages until every stage holds one; nothing is dropped or repeated.
module tracked_pose_frame_transform (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [63:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             system_running_i,
  input  logic             pen_tracking_i,
  input  logic             pen_connected_i,
  input  logic             reference_present_i,
  input  tpft_pkg::pword_t pen_pos_x_i,
  input  tpft_pkg::pword_t pen_pos_y_i,
  input  tpft_pkg::pword_t pen_pos_z_i,
  input  tpft_pkg::qword_t pen_rot_w_i,
  input  tpft_pkg::qword_t pen_rot_x_i,
  input  tpft_pkg::qword_t pen_rot_y_i,
  input  tpft_pkg::qword_t pen_rot_z_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             device_connected_o,
  output logic             pose_valid_o,
  output logic [1:0]       tracking_result_o,
  output tpft_pkg::pword_t out_pos_x_o,
  output tpft_pkg::pword_t out_pos_y_o,
  output tpft_pkg::pword_t out_pos_z_o,
  output tpft_pkg::qword_t out_rot_w_o,
  output tpft_pkg::qword_t out_rot_x_o,
  output tpft_pkg::qword_t out_rot_y_o,
  output tpft_pkg::qword_t out_rot_z_o
);
  import tpft_pkg::*;

  logic [63:0] orot_q, rrot_q;
  logic [62:0] otrn_q, rtrn_q;
  logic        kind_q;

  logic [8:0]  vld_q;
  logic [8:0]  en;
  status_t     st_d;
  status_t     st_q [9];
  vec_t        pp, pos;
  quat_t       qp, rot;
  logic        run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orot_q <= 64'h4000_0000_0000_0000;
      rrot_q <= 64'h4000_0000_0000_0000;
      otrn_q <= '0;
      rtrn_q <= '0;
      kind_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFS_ROT:  orot_q <= cfg_wdata_i;
        CFG_OFS_TRN:  otrn_q <= cfg_wdata_i[62:0];
        CFG_REF_ROT:  rrot_q <= cfg_wdata_i;
        CFG_REF_TRN:  rtrn_q <= cfg_wdata_i[62:0];
        CFG_REF_KIND: kind_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[8] = !vld_q[8] || out_ready_i;
    for (int s = 7; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  always_comb begin
    st_d = '{conn: 1'b1, run: 1'b0, res: TR_RUNNING};
    priority if (!system_running_i) begin
      st_d.conn = 1'b0;
      st_d.res  = TR_UNINIT;
    end else if (!pen_tracking_i || !pen_connected_i) begin
      st_d.res = TR_OUT_OF_RANGE;
    end else if (!reference_present_i) begin
      st_d.res = TR_CALIBRATING;
    end else begin
      st_d.run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < 9; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) st_q[0] <= st_d;
    for (int s = 1; s < 9; s++) begin
      if (en[s]) st_q[s] <= st_q[s-1];
    end
  end

  assign pp = '{pen_pos_x_i, pen_pos_y_i, pen_pos_z_i};
  assign qp = '{pen_rot_w_i, pen_rot_x_i, pen_rot_y_i, pen_rot_z_i};

  tpft_datapath u_dp (
    .clk_i,
    .en_i   (en),
    .pp_i   (pp),
    .qp_i   (qp),
    .qo_i   (unpack_q(orot_q)),
    .to_i   (unpack_p(otrn_q)),
    .qr_i   (unpack_q(rrot_q)),
    .tr_i   (unpack_p(rtrn_q)),
    .kind_i (kind_q),
    .pos_o  (pos),
    .rot_o  (rot)
  );

  assign in_ready_o         = en[0];
  assign out_valid_o        = vld_q[8];
  assign run                = st_q[8].run;
  assign device_connected_o = st_q[8].conn;
  assign pose_valid_o       = run;
  assign tracking_result_o  = st_q[8].res;
  assign out_pos_x_o        = run ? pos[0] : '0;
  assign out_pos_y_o        = run ? pos[1] : '0;
  assign out_pos_z_o        = run ? pos[2] : '0;
  assign out_rot_w_o        = run ? rot[0] : '0;
  assign out_rot_x_o        = run ? rot[1] : '0;
  assign out_rot_y_o        = run ? rot[2] : '0;
  assign out_rot_z_o        = run ? rot[3] : '0;

endmodule

@@ sv/tpft_checker.sv @@
module tpft_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             device_connected_o,
  input logic             pose_valid_o,
  input logic [1:0]       tracking_result_o,
  input tpft_pkg::pword_t out_pos_x_o,
  input tpft_pkg::pword_t out_pos_y_o,
  input tpft_pkg::pword_t out_pos_z_o,
  input tpft_pkg::qword_t out_rot_w_o,
  input tpft_pkg::qword_t out_rot_x_o,
  input tpft_pkg::qword_t out_rot_y_o,
  input tpft_pkg::qword_t out_rot_z_o
);
  import tpft_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_pos_x_o)
      && $stable(out_rot_w_o))
    else $error("output beat changed while stalled");

  a_valid_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pose_valid_o |-> tracking_result_o == TR_RUNNING && device_connected_o)
    else $error("valid pose without running status");

  a_zero_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pose_valid_o |-> out_pos_x_o == '0 && out_pos_y_o == '0
      && out_pos_z_o == '0 && out_rot_w_o == '0 && out_rot_x_o == '0
      && out_rot_y_o == '0 && out_rot_z_o == '0)
    else $error("non-running beat carries a pose");

  a_uninit_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tracking_result_o == TR_UNINIT |-> !device_connected_o)
    else $error("uninitialized status reports connected");

endmodule

bind tracked_pose_frame_transform tpft_checker u_tpft_checker (.*);
